>>> sv/damage_rect_merge_list_top_assert.svh
// Assertion macros used by the damage rectangle list top module.
`ifndef DAMAGE_RECT_MERGE_LIST_TOP_ASSERT_SVH
`define DAMAGE_RECT_MERGE_LIST_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRML_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drml assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DRML_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drml assertion failed one cycle later");

`endif

>>> sv/drml_pkg.sv
// Package with the types and constants of the damage rectangle list.
`default_nettype none
package drml_pkg;

  localparam int COORD_BITS = 16;
  localparam int CNT_BITS = COORD_BITS + 1;
  localparam int EXT_W = COORD_BITS + CNT_BITS;
  localparam int ENTRY_W = 2 * EXT_W;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int CAP_W = 7;
  localparam int CAP_RESET = 64;
  localparam int READ_IDX_W = 6;

  // Register byte addresses.
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  // Command codes.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Sticky status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPEND,
    S_READ,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> sv/drml_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module drml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/damage_rect_merge_list_top.sv
// An add is checked, then scans the stored entries until one merges or the last one is seen,
// and is appended only if none merged; the done state registers the result for output.
// A read within the list reads its entry after the check; clear, unused commands, invalid adds
// and reads past the list go from the check state straight to done. One request is in flight
// at a time; the scan reads one RAM entry per cycle through a single shared union/overlap unit.
// Synchronous reset empties the list, sets status ok and capacity 64; the RAM is left as is.
`default_nettype none
module damage_rect_merge_list_top #(
  parameter int MAX_ENTRIES = drml_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        cmd,
  input  wire logic [drml_pkg::COORD_BITS-1:0]   rect_row_start,
  input  wire logic [drml_pkg::CNT_BITS-1:0]     rect_row_count,
  input  wire logic [drml_pkg::COORD_BITS-1:0]   rect_col_start,
  input  wire logic [drml_pkg::CNT_BITS-1:0]     rect_col_count,
  input  wire logic [drml_pkg::READ_IDX_W-1:0]   read_index,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   accepted,
  output logic                                   merged,
  output logic [1:0]                             status_code,
  output logic [drml_pkg::CAP_W-1:0]             entry_count,
  output logic [drml_pkg::COORD_BITS-1:0]        out_row_start,
  output logic [drml_pkg::CNT_BITS-1:0]          out_row_count,
  output logic [drml_pkg::COORD_BITS-1:0]        out_col_start,
  output logic [drml_pkg::CNT_BITS-1:0]          out_col_count,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [1:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import drml_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WIDE_W = (CW > CAP_W) ? CW : CAP_W;
  localparam int SUM_W = CNT_BITS + 1;

  state_t state, state_next;

  // Control state.
  logic [CW-1:0]        count;
  logic [1:0]           status;
  logic [CAP_W-1:0]     cap;
  logic [AW-1:0]        scan_idx;

  // Latched request.
  logic [1:0]            req_cmd;
  logic [COORD_BITS-1:0] req_rs, req_cs;
  logic [CNT_BITS-1:0]   req_rc, req_cc;
  logic [READ_IDX_W-1:0] req_ri;

  // Working result and the output register.
  logic                  w_accepted, w_merged;
  logic [ENTRY_W-1:0]    w_rect;
  logic [ENTRY_W-1:0]    out_rect;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  drml_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Count and capacity comparisons at a common width.
  logic [WIDE_W-1:0] count_w, cap_w;
  logic              list_full, read_ok, scan_last;
  assign count_w   = WIDE_W'(count);
  assign cap_w     = WIDE_W'(cap);
  assign list_full = (count_w >= cap_w) || (count_w >= WIDE_W'(MAX_ENTRIES));
  assign read_ok   = WIDE_W'(req_ri) < count_w;
  assign scan_last = (WIDE_W'(scan_idx) + WIDE_W'(1)) == count_w;

  // Rectangle validity: nonzero counts and ends within the coordinate space.
  logic [SUM_W-1:0] row_end, col_end;
  logic             rect_bad;
  assign row_end  = SUM_W'(req_rs) + SUM_W'(req_rc);
  assign col_end  = SUM_W'(req_cs) + SUM_W'(req_cc);
  assign rect_bad = (req_rc == '0) || (req_cc == '0) ||
                    (row_end > SUM_W'(1 << COORD_BITS)) ||
                    (col_end > SUM_W'(1 << COORD_BITS));

  // Split the stored entry being scanned.
  logic [EXT_W-1:0] e_row, e_col;
  logic             row_eq, col_eq, sel_col;
  assign e_row   = ram_rdata[ENTRY_W-1:EXT_W];
  assign e_col   = ram_rdata[EXT_W-1:0];
  assign row_eq  = e_row == {req_rs, req_rc};
  assign col_eq  = e_col == {req_cs, req_cc};
  assign sel_col = row_eq;

  // Shared union unit, working on the column axis when rows match, else on rows.
  logic [COORD_BITS-1:0] u_es, u_ns, u_lo;
  logic [CNT_BITS-1:0]   u_ec, u_nc, u_cnt;
  logic [SUM_W-1:0]      u_ee, u_ne, u_hi;
  logic                  u_touch, hit;
  assign u_es    = sel_col ? e_col[EXT_W-1:CNT_BITS] : e_row[EXT_W-1:CNT_BITS];
  assign u_ec    = sel_col ? e_col[CNT_BITS-1:0] : e_row[CNT_BITS-1:0];
  assign u_ns    = sel_col ? req_cs : req_rs;
  assign u_nc    = sel_col ? req_cc : req_rc;
  assign u_ee    = SUM_W'(u_es) + SUM_W'(u_ec);
  assign u_ne    = SUM_W'(u_ns) + SUM_W'(u_nc);
  assign u_touch = !((SUM_W'(u_ns) > u_ee) || (SUM_W'(u_es) > u_ne));
  assign u_lo    = (u_es < u_ns) ? u_es : u_ns;
  assign u_hi    = (u_ee > u_ne) ? u_ee : u_ne;
  assign u_cnt   = CNT_BITS'(u_hi - SUM_W'(u_lo));
  assign hit     = (row_eq || col_eq) && u_touch;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (req_cmd)
          CMD_ADD: begin
            if (rect_bad) begin
              state_next = S_DONE;
            end else if (count == '0) begin
              state_next = S_APPEND;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_READ: state_next = read_ok ? S_READ : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_DONE;
        end else if (scan_last) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: state_next = S_DONE;
      S_READ:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM control and handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = scan_idx;
    ram_wdata = sel_col ? {e_row, u_lo, u_cnt} : {u_lo, u_cnt, e_col};
    ram_raddr = '0;
    unique case (state)
      S_IDLE: in_ready = !rst;
      S_CHECK: begin
        if (req_cmd == CMD_READ) begin
          ram_raddr = AW'(req_ri);
        end
      end
      S_SCAN: begin
        ram_raddr = scan_idx + AW'(1);
        ram_we    = hit;
      end
      S_APPEND: begin
        ram_we    = !list_full;
        ram_waddr = AW'(count);
        ram_wdata = {req_rs, req_rc, req_cs, req_cc};
      end
      S_READ, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      status    <= ST_OK;
      cap       <= CAP_W'(CAP_RESET);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        cap <= pwdata[CAP_W-1:0];
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_CHECK) begin
        if (req_cmd == CMD_ADD && rect_bad) begin
          status <= ST_INVALID;
        end else if (req_cmd == CMD_CLEAR) begin
          count  <= '0;
          status <= ST_OK;
        end
      end
      if (state == S_APPEND) begin
        if (list_full) begin
          status <= ST_OVERFLOW;
        end else begin
          count <= count + CW'(1);
        end
      end
    end
  end

  // Request, scan index, working result and output payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd <= cmd;
      req_rs  <= rect_row_start;
      req_rc  <= rect_row_count;
      req_cs  <= rect_col_start;
      req_cc  <= rect_col_count;
      req_ri  <= read_index;
    end
    unique case (state)
      S_CHECK: begin
        scan_idx   <= '0;
        w_accepted <= (req_cmd == CMD_READ) && read_ok;
        w_merged   <= 1'b0;
        w_rect     <= '0;
      end
      S_SCAN: begin
        scan_idx <= scan_idx + AW'(1);
        if (hit) begin
          w_accepted <= 1'b1;
          w_merged   <= 1'b1;
        end
      end
      S_APPEND: begin
        if (!list_full) begin
          w_accepted <= 1'b1;
        end
      end
      S_READ: w_rect <= ram_rdata;
      S_DONE: begin
        if (out_free) begin
          accepted    <= w_accepted;
          merged      <= w_merged;
          status_code <= status;
          entry_count <= count_w[CAP_W-1:0];
          out_rect    <= w_rect;
        end
      end
      S_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_row_start = out_rect[ENTRY_W-1:EXT_W+CNT_BITS];
  assign out_row_count = out_rect[EXT_W+CNT_BITS-1:EXT_W];
  assign out_col_start = out_rect[EXT_W-1:CNT_BITS];
  assign out_col_count = out_rect[CNT_BITS-1:0];

  // Configuration read-back; the port never stalls.
  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(cap) : '0;
  assign pready = 1'b1;

`include "damage_rect_merge_list_top_assert.svh"

  `DRML_ASSERT_SAME(a_ram_write_state, ram_we, (state == S_SCAN) || (state == S_APPEND))
  `DRML_ASSERT_SAME(a_scan_in_list, state == S_SCAN, WIDE_W'(scan_idx) < count_w)
  `DRML_ASSERT_NEXT(a_append_counts, (state == S_APPEND) && ram_we, count == $past(count) + CW'(1))
  `DRML_ASSERT_SAME(a_count_bound, 1'b1, count_w <= WIDE_W'(MAX_ENTRIES))
  `DRML_ASSERT_SAME(a_status_code, 1'b1, status <= ST_OVERFLOW)

endmodule
`default_nettype wire
